// File: design/life_automaton_generation_assert.svh
// Assertion macros shared by the life automaton generation RTL
`ifndef LIFE_AUTOMATON_GENERATION_ASSERT_SVH
`define LIFE_AUTOMATON_GENERATION_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define LGEN_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define LGEN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/lgen_pkg.sv
// Package: sizes, register codes, window masks and shared types of the life generation block
`timescale 1ns / 1ps

package lgen_pkg;

	// Board limits and derived widths
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	// input row runs up to height+1 during the flush items
	localparam int IN_ROW_W   = ROW_W + 1;

	// Fixed field widths
	localparam int DIM_W     = 11;
	localparam int POS_W     = 10;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOARD_WIDTH  = 2'd0,
		REG_BOARD_HEIGHT = 2'd1
	} cfg_reg_t;

	// 3x3 window, bit = 3*column + row, column 0 is the oldest (left)
	localparam logic [8:0] WIN_LEFT   = 9'h007;
	localparam logic [8:0] WIN_RIGHT  = 9'h1C0;
	localparam logic [8:0] WIN_TOP    = 9'h049;
	localparam logic [8:0] WIN_BOTTOM = 9'h124;
	localparam logic [8:0] WIN_CENTRE = 9'h010;

	// B3/S23 rule counts
	localparam logic [3:0] BIRTH_COUNT = 4'd3;
	localparam logic [3:0] STAY_COUNT  = 4'd2;

	// Per-item bookkeeping decided when the item is taken
	typedef struct packed {
		logic             emit;
		logic             last;
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
		logic [8:0]       mask;
	} lgen_tag_t;

	// Effective board size, minus one
	typedef struct packed {
		logic [COL_W-1:0] w_m1;
		logic [ROW_W-1:0] h_m1;
	} lgen_dims_t;

endpackage

// File: design/lgen_if.sv
// Interfaces: cell input channel, result channel and configuration write channel
`timescale 1ns / 1ps

interface lgen_cell_if;
	logic valid;
	logic ready;
	logic mode;
	logic cell_alive;

	modport source (output valid, output mode, output cell_alive, input ready);
	modport sink (input valid, input mode, input cell_alive, output ready);
endinterface

interface lgen_result_if import lgen_pkg::*; ;
	logic             valid;
	logic             ready;
	logic             next_alive;
	logic [POS_W-1:0] cell_row;
	logic [POS_W-1:0] cell_col;
	logic             last_of_generation;

	modport source (output valid, output next_alive, output cell_row, output cell_col,
		output last_of_generation, input ready);
	modport sink (input valid, input next_alive, input cell_row, input cell_col,
		input last_of_generation, output ready);
endinterface

interface lgen_cfg_if import lgen_pkg::*; ;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIM_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/lgen_linebuf.sv
// Two stacked line buffers in one memory: bit 1 one row up, bit 0 two rows up
`timescale 1ns / 1ps

module lgen_linebuf import lgen_pkg::*; (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [COL_W-1:0] rd_addr,
	output logic [1:0]       rd_data,
	input  logic             wr_en,
	input  logic [COL_W-1:0] wr_addr,
	input  logic [1:0]       wr_data
);

	logic [1:0] mem_q [MAX_WIDTH];
	logic [1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read, forwarding a write to the same column (one-column boards)
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/lgen_scan.sv
// Raster position tracking, board size registers and per-item edge masks
`timescale 1ns / 1ps

module lgen_scan import lgen_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 accept,
	output lgen_tag_t            tag,
	output lgen_dims_t           dims,
	output logic [COL_W-1:0]     rd_addr
);

	logic [DIM_W-1:0]    width_q, height_q;
	logic [COL_W-1:0]    in_col_q, out_col_q;
	logic [IN_ROW_W-1:0] in_row_q;
	logic [ROW_W-1:0]    out_row_q;
	logic                col_end, row_end;
	logic                wr_width, wr_height;

	// Clamp the size registers to 1..MAX
	always_comb begin
		if (width_q == '0) begin
			dims.w_m1 = '0;
		end else if (32'(width_q) > MAX_WIDTH) begin
			dims.w_m1 = COL_W'(MAX_WIDTH - 1);
		end else begin
			dims.w_m1 = COL_W'(width_q - 1'b1);
		end
		if (height_q == '0) begin
			dims.h_m1 = '0;
		end else if (32'(height_q) > MAX_HEIGHT) begin
			dims.h_m1 = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			dims.h_m1 = ROW_W'(height_q - 1'b1);
		end
	end

	// Result tag for the item at the input: emitted once width+1 items are in
	always_comb begin
		col_end     = (out_col_q == dims.w_m1);
		row_end     = (out_row_q == dims.h_m1);
		tag.emit    = (in_row_q >= IN_ROW_W'(2)) ||
			((in_row_q == IN_ROW_W'(1)) && (in_col_q != '0));
		tag.last    = tag.emit && col_end && row_end;
		tag.out_row = out_row_q;
		tag.out_col = out_col_q;
		tag.mask    = 9'h1FF;
		if (out_col_q == '0) tag.mask = tag.mask & ~WIN_LEFT;
		if (col_end)         tag.mask = tag.mask & ~WIN_RIGHT;
		if (out_row_q == '0) tag.mask = tag.mask & ~WIN_TOP;
		if (row_end)         tag.mask = tag.mask & ~WIN_BOTTOM;
	end

	assign rd_addr   = in_col_q;
	assign wr_width  = cfg_wr && (cfg_index == REG_BOARD_WIDTH);
	assign wr_height = cfg_wr && (cfg_index == REG_BOARD_HEIGHT);

	// Size registers and position counters; a size write or the last result restarts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= DIM_W'(64);
			height_q  <= DIM_W'(64);
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (wr_width || wr_height) begin
			if (wr_width)  width_q  <= cfg_data;
			if (wr_height) height_q <= cfg_data;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			if (tag.last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_q == dims.w_m1) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
				if (tag.emit) begin
					if (col_end) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + 1'b1;
					end else begin
						out_col_q <= out_col_q + 1'b1;
					end
				end
			end
		end
	end

endmodule

// File: design/lgen_window.sv
// 3x3 neighborhood window and the B3/S23 next-state rule
`timescale 1ns / 1ps

module lgen_window import lgen_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       clear,
	input  logic       advance,
	input  logic       restart,
	input  logic [2:0] column,
	input  logic [8:0] mask,
	output logic       next_alive
);

	logic [8:0] window_q;
	logic [8:0] window_new;
	logic [8:0] live;
	logic [3:0] count;

	// Shift the new column in on the right
	assign window_new = {column, window_q[8:3]};
	assign live       = window_new & mask & ~WIN_CENTRE;

	// Neighbor count and rule
	always_comb begin
		count = '0;
		for (int i = 0; i < 9; i++) begin
			count = count + 4'(live[i]);
		end
		if (window_new[4]) begin
			next_alive = (count == STAY_COUNT) || (count == BIRTH_COUNT);
		end else begin
			next_alive = (count == BIRTH_COUNT);
		end
	end

	// Window register, emptied at the end of a generation and on a size write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (clear) begin
			window_q <= '0;
		end else if (advance) begin
			window_q <= restart ? '0 : window_new;
		end
	end

endmodule

// File: design/life_automaton_generation.sv
// Top level: one generation of the B3/S23 life automaton over a raster cell stream
//
// Usage:
//   cells   - one transaction per board cell in raster order (mode 0), then
//             board_width+1 flush transactions (mode 1) to drain the frame.
//   results - one transaction per board cell, raster order, carrying the next
//             state, its row/column and last_of_generation on the final cell.
//   cfg     - register 0 board_width, register 1 board_height (1..1024,
//             0 acts as 1). A write restarts the generation; write only idle.
// Throughput: one cell per clock, with no gaps while results.ready stays high.
// Order: a result is produced by the input transaction board_width+1 cells
//   later; that transaction passes the input register with line buffer
//   read, then the result register.
// Stall: the result register holds while results.ready is low; the input
//   register then fills and cells.ready drops until the result is taken.
// Reset: arst_n clears positions, window and valid flags; sizes return to 64.
//   Line buffer contents are not cleared; stale columns fall outside the board.
`timescale 1ns / 1ps

`include "life_automaton_generation_assert.svh"

module life_automaton_generation import lgen_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	lgen_cell_if.sink        cells,
	lgen_result_if.source    results,
	lgen_cfg_if.sink         cfg
);

	logic             accept;
	logic             cfg_hit;
	logic             cell_in;
	lgen_tag_t        scan_tag;
	lgen_dims_t       dims;
	logic [COL_W-1:0] rd_addr;
	logic [1:0]       rd_data;

	logic             s1_valid_q;
	logic             cell_s1;
	lgen_tag_t        tag_s1;
	logic [COL_W-1:0] col_s1;
	logic             s1_adv;
	logic             next_alive;

	logic             out_valid_q;
	logic             next_alive_q;
	logic [POS_W-1:0] cell_row_q;
	logic [POS_W-1:0] cell_col_q;
	logic             last_q;

	// Handshakes
	assign cfg.ready   = 1'b1;
	assign cfg_hit     = cfg.valid &&
		((cfg.index == REG_BOARD_WIDTH) || (cfg.index == REG_BOARD_HEIGHT));
	assign s1_adv      = s1_valid_q && (!tag_s1.emit || !out_valid_q || results.ready);
	assign cells.ready = !s1_valid_q || s1_adv;
	assign accept      = cells.valid && cells.ready;
	assign cell_in     = cells.mode ? 1'b0 : cells.cell_alive;

	lgen_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.accept    (accept),
		.tag       (scan_tag),
		.dims      (dims),
		.rd_addr   (rd_addr)
	);

	// Line buffers: read at accept, updated when the cell leaves the input register
	lgen_linebuf u_linebuf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data ({cell_s1, rd_data[1]})
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1 <= cell_in;
			tag_s1  <= scan_tag;
			col_s1  <= rd_addr;
		end
	end

	lgen_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (cfg_hit),
		.advance    (s1_adv),
		.restart    (tag_s1.last),
		.column     ({cell_s1, rd_data[1], rd_data[0]}),
		.mask       (tag_s1.mask),
		.next_alive (next_alive)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && tag_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && tag_s1.emit) begin
			next_alive_q <= next_alive;
			cell_row_q   <= POS_W'(tag_s1.out_row);
			cell_col_q   <= POS_W'(tag_s1.out_col);
			last_q       <= tag_s1.last;
		end
	end

	assign results.valid              = out_valid_q;
	assign results.next_alive         = next_alive_q;
	assign results.cell_row           = cell_row_q;
	assign results.cell_col           = cell_col_q;
	assign results.last_of_generation = last_q;

	// Checks
	`LGEN_ASSERT_NEXT(a_restart_after_last, accept && scan_tag.last,
		!scan_tag.emit && (scan_tag.out_row == '0) && (scan_tag.out_col == '0),
		"positions not cleared after the final cell")
	`LGEN_ASSERT_NEXT(a_restart_after_cfg, cfg_hit,
		!scan_tag.emit && (scan_tag.out_row == '0) && (scan_tag.out_col == '0),
		"positions not cleared after a size write")
	`LGEN_ASSERT_NOW(a_last_is_corner, results.valid && results.last_of_generation,
		(results.cell_col == POS_W'(dims.w_m1)) && (results.cell_row == POS_W'(dims.h_m1)),
		"last_of_generation away from the final cell")
	`LGEN_ASSERT_NOW(a_result_on_board, results.valid,
		(results.cell_col <= POS_W'(dims.w_m1)) && (results.cell_row <= POS_W'(dims.h_m1)),
		"result position outside the board")

endmodule
